### rtl/button_debounce_long_press_repeat_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce block
// Shared concurrent check forms, clocked on the rising edge and disabled
// while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_MACROS_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_MACROS_SVH

// Same-cycle implication.
`define BDLPR_CHECK_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BDLPR_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bdlpr_pkg.sv
// ----------------------------------------------------------------------------
// bdlpr_pkg
// Types and constants shared by the button debounce lanes, the result
// merge stage and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bdlpr_pkg;

    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RST        = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST      = 16'd500;
    localparam logic [CFG_W-1:0] INITIAL_REPEAT_RST  = 16'd300;
    localparam logic [CFG_W-1:0] RPT_PERIOD_RST      = 16'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE        = 2'd0,
        CFG_LONG_PRESS      = 2'd1,
        CFG_INITIAL_REPEAT  = 2'd2,
        CFG_RPT_PERIOD      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] debounce;
        logic [CFG_W-1:0] long_press;
        logic [CFG_W-1:0] initial_repeat;
        logic [CFG_W-1:0] rpt_period;
    } t_cfg;

    // Per-button status after the current tick
    typedef struct packed {
        logic latched;
        logic held;
        logic long_press;
        logic repeat_pulse;
    } t_lane_flags;

endpackage

`default_nettype wire

### rtl/bdlpr_lane.sv
// ----------------------------------------------------------------------------
// bdlpr_lane
// One button: debounce, press latch, long-press detect and auto-repeat.
// All stamp differences are computed in parallel against the stored stamps.
// ----------------------------------------------------------------------------
`default_nettype none
`include "button_debounce_long_press_repeat_macros.svh"

module bdlpr_lane (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic [bdlpr_pkg::TIME_W-1:0]   i_now,
    input  logic                           i_raw,
    input  logic                           i_ack,
    input  logic                           i_clr,
    input  bdlpr_pkg::t_cfg                i_cfg,
    output bdlpr_pkg::t_lane_flags         o_flags
);
    import bdlpr_pkg::*;

    logic              r_prev, r_stable, r_latch, r_long;
    logic [TIME_W-1:0] r_change_stamp, r_press_stamp, r_repeat_stamp;

    logic              n_prev, n_stable, n_latch, n_long;
    logic [TIME_W-1:0] n_change_stamp, n_press_stamp, n_repeat_stamp;

    logic              prev0, stable0, latch0, long0, long1;
    logic              chg, accept, press, long_go, fire;
    logic [TIME_W-1:0] since_chg, since_start, since_rep;
    logic [CFG_W:0]    lp_ir;
    logic [CFG_W-1:0]  delay;

    always_comb begin
        // clear-all, then ack, act before the update
        prev0   = i_clr ? 1'b0 : r_prev;
        stable0 = i_clr ? 1'b0 : r_stable;
        long0   = i_clr ? 1'b0 : r_long;
        latch0  = (i_clr | i_ack) ? 1'b0 : r_latch;

        chg            = (i_raw != prev0);
        n_change_stamp = chg ? i_now : r_change_stamp;
        since_chg      = chg ? '0 : (i_now - r_change_stamp);

        accept   = (since_chg > TIME_W'(i_cfg.debounce)) && (i_raw != stable0);
        press    = accept & i_raw;
        n_stable = accept ? i_raw : stable0;
        long1    = accept ? 1'b0 : long0;
        n_latch  = press | latch0;
        n_press_stamp = press ? i_now : r_press_stamp;

        since_start = press ? '0 : (i_now - r_press_stamp);
        long_go     = n_stable & ~long1 & (since_start >= TIME_W'(i_cfg.long_press));
        n_long      = long1 | long_go;

        // a fresh stamp of now gives a zero difference
        since_rep = (press | long_go) ? '0 : (i_now - r_repeat_stamp);
        lp_ir     = {1'b0, i_cfg.long_press} + {1'b0, i_cfg.initial_repeat};
        delay     = (since_start < TIME_W'(lp_ir)) ? i_cfg.initial_repeat
                                                   : i_cfg.rpt_period;
        fire      = n_long & (since_rep >= TIME_W'(delay));

        n_repeat_stamp = (press | long_go | fire) ? i_now : r_repeat_stamp;
        n_prev         = i_raw;
    end

    always_comb begin
        o_flags.latched      = n_latch;
        o_flags.held         = n_stable;
        o_flags.long_press   = n_long;
        o_flags.repeat_pulse = fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev         <= 1'b0;
            r_stable       <= 1'b0;
            r_latch        <= 1'b0;
            r_long         <= 1'b0;
            r_change_stamp <= '0;
            r_press_stamp  <= '0;
            r_repeat_stamp <= '0;
        end else if (i_en) begin
            r_prev         <= n_prev;
            r_stable       <= n_stable;
            r_latch        <= n_latch;
            r_long         <= n_long;
            r_change_stamp <= n_change_stamp;
            r_press_stamp  <= n_press_stamp;
            r_repeat_stamp <= n_repeat_stamp;
        end
    end

    `BDLPR_CHECK_NOW(a_long_needs_held, i_clk, i_rst_n, r_long, r_stable,
                     "long press without held level")
    `BDLPR_CHECK_NOW(a_fire_needs_long, i_clk, i_rst_n, fire, n_long,
                     "repeat pulse without long press")
    `BDLPR_CHECK_NEXT(a_press_latches, i_clk, i_rst_n, i_en && press, r_latch && r_stable,
                      "accepted press not latched")

endmodule

`default_nettype wire

### rtl/bdlpr_merge.sv
// ----------------------------------------------------------------------------
// bdlpr_merge
// Packs the lane flags into the four result vectors and holds them in an
// output register backed by a one-entry skid stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "button_debounce_long_press_repeat_macros.svh"

module bdlpr_merge #(
    parameter int NUM_BUTTONS = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  bdlpr_pkg::t_lane_flags       i_flags [NUM_BUTTONS],
    output logic                         o_full,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [NUM_BUTTONS-1:0]       o_pressed_latched,
    output logic [NUM_BUTTONS-1:0]       o_held,
    output logic [NUM_BUTTONS-1:0]       o_long_press,
    output logic [NUM_BUTTONS-1:0]       o_repeat_pulse
);
    import bdlpr_pkg::*;

    logic [NUM_BUTTONS-1:0] w_latch, w_held, w_long, w_rep;

    logic                   r_out_valid, r_skid_valid;
    logic [NUM_BUTTONS-1:0] r_out_latch, r_out_held, r_out_long, r_out_rep;
    logic [NUM_BUTTONS-1:0] r_skid_latch, r_skid_held, r_skid_long, r_skid_rep;
    logic                   pop;

    always_comb begin
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            w_latch[b] = i_flags[b].latched;
            w_held[b]  = i_flags[b].held;
            w_long[b]  = i_flags[b].long_press;
            w_rep[b]   = i_flags[b].repeat_pulse;
        end
    end

    assign pop = r_out_valid & ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop || !r_out_valid) begin
            r_out_valid  <= r_skid_valid | i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_latch <= r_skid_latch;
                r_out_held  <= r_skid_held;
                r_out_long  <= r_skid_long;
                r_out_rep   <= r_skid_rep;
            end else begin
                r_out_latch <= w_latch;
                r_out_held  <= w_held;
                r_out_long  <= w_long;
                r_out_rep   <= w_rep;
            end
        end else if (i_push) begin
            r_skid_latch <= w_latch;
            r_skid_held  <= w_held;
            r_skid_long  <= w_long;
            r_skid_rep   <= w_rep;
        end
    end

    assign o_full            = r_skid_valid;
    assign o_out_valid       = r_out_valid;
    assign o_pressed_latched = r_out_latch;
    assign o_held            = r_out_held;
    assign o_long_press      = r_out_long;
    assign o_repeat_pulse    = r_out_rep;

    `BDLPR_CHECK_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid entry without output entry")
    `BDLPR_CHECK_NEXT(a_stall_fills_skid, i_clk, i_rst_n, i_push && r_out_valid && i_out_stall, r_skid_valid, "stalled result dropped")
    `BDLPR_CHECK_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && !i_out_stall, r_out_valid && !r_skid_valid, "skid entry not moved out")

endmodule

`default_nettype wire

### rtl/button_debounce_long_press_repeat.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press_repeat
// Debounce, press latch, long press and auto-repeat for a bank of buttons.
// ----------------------------------------------------------------------------
// Each input transfer is one millisecond tick. The block takes one tick per
// clock cycle when not stalled; each result goes to the output register,
// or to the skid entry while that register is held. All buttons are updated
// in parallel by one lane each, and each lane's state is ready for the next
// tick right away. A two-entry output buffer (output register plus skid)
// lets a tick be taken while a result waits; the input stalls only when both
// entries are full. The user must write timing registers through the plain
// write port only while no tick is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_long_press_repeat #(
    parameter int NUM_BUTTONS = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tick input
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [NUM_BUTTONS-1:0]            i_raw_levels,
    input  logic [NUM_BUTTONS-1:0]            i_ack_pressed,
    input  logic                              i_clear_all,
    // result output
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [NUM_BUTTONS-1:0]            o_pressed_latched,
    output logic [NUM_BUTTONS-1:0]            o_held,
    output logic [NUM_BUTTONS-1:0]            o_long_press,
    output logic [NUM_BUTTONS-1:0]            o_repeat_pulse,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [bdlpr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bdlpr_pkg::CFG_W-1:0]       i_cfg_data
);
    import bdlpr_pkg::*;

    t_cfg              r_cfg;
    logic [TIME_W-1:0] r_tick;
    logic              w_push;
    logic              w_full;
    t_lane_flags       w_flags [NUM_BUTTONS];

    assign w_push     = i_in_valid & ~w_full;
    assign o_in_stall = w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce        <= DEBOUNCE_RST;
            r_cfg.long_press      <= LONG_PRESS_RST;
            r_cfg.initial_repeat  <= INITIAL_REPEAT_RST;
            r_cfg.rpt_period      <= RPT_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE:        r_cfg.debounce        <= i_cfg_data;
                CFG_LONG_PRESS:      r_cfg.long_press      <= i_cfg_data;
                CFG_INITIAL_REPEAT:  r_cfg.initial_repeat  <= i_cfg_data;
                CFG_RPT_PERIOD:      r_cfg.rpt_period      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // tick time, wraps modulo 2^32
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
        end else if (w_push) begin
            r_tick <= r_tick + TIME_W'(1);
        end
    end

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        bdlpr_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_push),
            .i_now   (r_tick),
            .i_raw   (i_raw_levels[g]),
            .i_ack   (i_ack_pressed[g]),
            .i_clr   (i_clear_all),
            .i_cfg   (r_cfg),
            .o_flags (w_flags[g])
        );
    end

    bdlpr_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (w_push),
        .i_flags           (w_flags),
        .o_full            (w_full),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_pressed_latched (o_pressed_latched),
        .o_held            (o_held),
        .o_long_press      (o_long_press),
        .o_repeat_pulse    (o_repeat_pulse)
    );

endmodule

`default_nettype wire
